// File: hw/rtl/stc_pkg.sv
package stc_pkg;

  localparam logic [4:0] KIND_ID         = 5'd0;
  localparam logic [4:0] KIND_INT        = 5'd1;
  localparam logic [4:0] KIND_STRING     = 5'd2;
  localparam logic [4:0] KIND_OP         = 5'd3;
  localparam logic [4:0] KIND_ASSIGN     = 5'd4;
  localparam logic [4:0] KIND_COMP       = 5'd5;
  localparam logic [4:0] KIND_LPAREN     = 5'd6;
  localparam logic [4:0] KIND_RPAREN     = 5'd7;
  localparam logic [4:0] KIND_LBRACE     = 5'd8;
  localparam logic [4:0] KIND_RBRACE     = 5'd9;
  localparam logic [4:0] KIND_LBRACKET   = 5'd10;
  localparam logic [4:0] KIND_RBRACKET   = 5'd11;
  localparam logic [4:0] KIND_COMMA      = 5'd12;
  localparam logic [4:0] KIND_DOT        = 5'd13;
  localparam logic [4:0] KIND_COLON      = 5'd14;
  localparam logic [4:0] KIND_SEMICOLON  = 5'd15;
  localparam logic [4:0] KIND_UNKNOWN    = 5'd16;

  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_LESS       = 8'h3C;
  localparam logic [7:0] CH_GREATER    = 8'h3E;
  localparam logic [7:0] CH_BANG       = 8'h21;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SEMICOLON  = 8'h3B;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        overflow;
    logic        last;
  } token_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
           (c == CH_EQUAL) || (c == CH_BANG) || (c == CH_LESS) || (c == CH_GREATER);
  endfunction

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t r;
    r.hit = 1'b1;
    unique case (c)
      CH_LPAREN:    r.kind = KIND_LPAREN;
      CH_RPAREN:    r.kind = KIND_RPAREN;
      CH_LBRACE:    r.kind = KIND_LBRACE;
      CH_RBRACE:    r.kind = KIND_RBRACE;
      CH_LBRACKET:  r.kind = KIND_LBRACKET;
      CH_RBRACKET:  r.kind = KIND_RBRACKET;
      CH_COMMA:     r.kind = KIND_COMMA;
      CH_DOT:       r.kind = KIND_DOT;
      CH_COLON:     r.kind = KIND_COLON;
      CH_SEMICOLON: r.kind = KIND_SEMICOLON;
      default: begin
        r.hit  = 1'b0;
        r.kind = KIND_UNKNOWN;
      end
    endcase
    return r;
  endfunction

  function automatic logic [4:0] lone_oper_kind(input logic [7:0] h);
    if (h == CH_EQUAL) return KIND_ASSIGN;
    if (h == CH_LESS || h == CH_GREATER) return KIND_COMP;
    return KIND_OP;
  endfunction

endpackage

// File: hw/rtl/source_char_tokenizer.sv
// output: a token is registered into the token queue when the character that ends it is accepted
// throughput: one character per cycle; a character that closes two tokens queues both, which
// leave the output one at a time, and the input stalls while more than two tokens wait in the 4-entry queue
// reset: synchronous active-high rst returns the scanner to idle at position zero
// and empties the token queue
module source_char_tokenizer #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_source,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [15:0] token_start,
  output logic [15:0] token_length,
  output logic [7:0]  text_first,
  output logic [7:0]  text_second,
  output logic        offset_overflow,
  output logic        last_of_run
);

  localparam int EXT_BITS = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_STRING,
    MODE_OPER
  } mode_t;

  function automatic logic [15:0] clamp16(input logic [OFFSET_BITS-1:0] v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return (e > EXT_BITS'(17'h0FFFF)) ? 16'hFFFF : e[15:0];
  endfunction

  mode_t                  scan_mode, scan_mode_next;
  logic [7:0]             held_operator, held_operator_next;
  logic [OFFSET_BITS-1:0] token_begin, token_begin_next;
  logic [OFFSET_BITS-1:0] token_count, token_count_next;
  logic [OFFSET_BITS-1:0] char_position, char_position_next;
  logic                   position_saturated, position_saturated_next;

  stc_pkg::token_t tok_fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill, fill_next;

  logic in_accept, out_accept;
  logic do_flush, run_idle, idle_ok, ovf;
  logic [1:0] n_tok;
  stc_pkg::token_t flush_tok, idle_tok, slot0, slot1;
  stc_pkg::punct_t pk;

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = fill > 3'd2;
  assign out_valid  = fill != 3'd0;

  always_comb begin
    scan_mode_next          = scan_mode;
    held_operator_next      = held_operator;
    token_begin_next        = token_begin;
    token_count_next        = token_count;
    char_position_next      = char_position;
    position_saturated_next = position_saturated;
    do_flush = 1'b0;
    run_idle = 1'b0;
    idle_ok  = 1'b0;
    pk       = stc_pkg::punct_lookup(char_code);

    // pending token as it would be flushed
    flush_tok        = '0;
    flush_tok.start  = clamp16(token_begin);
    flush_tok.length = clamp16(token_count);
    unique case (scan_mode)
      MODE_IDENT:  flush_tok.kind = stc_pkg::KIND_ID;
      MODE_INT:    flush_tok.kind = stc_pkg::KIND_INT;
      MODE_STRING: flush_tok.kind = stc_pkg::KIND_STRING;
      MODE_OPER: begin
        flush_tok.kind   = stc_pkg::lone_oper_kind(held_operator);
        flush_tok.length = 16'd1;
        flush_tok.first  = held_operator;
      end
      default: flush_tok.kind = stc_pkg::KIND_ID;
    endcase

    idle_tok = '0;
    ovf = end_of_source ? position_saturated
                        : (position_saturated || (char_position == POS_MAX));

    if (in_accept) begin
      if (end_of_source) begin
        do_flush                = (scan_mode != MODE_IDLE);
        scan_mode_next          = MODE_IDLE;
        held_operator_next      = '0;
        token_begin_next        = '0;
        token_count_next        = '0;
        char_position_next      = '0;
        position_saturated_next = 1'b0;
      end else begin
        if (char_position == POS_MAX) position_saturated_next = 1'b1;
        else char_position_next = char_position + 1'b1;

        unique case (scan_mode)
          MODE_IDENT, MODE_INT: begin
            if (stc_pkg::is_digit(char_code) || (scan_mode == MODE_IDENT &&
                (stc_pkg::is_alpha(char_code) || char_code == stc_pkg::CH_UNDERSCORE))) begin
              if (token_count == POS_MAX) position_saturated_next = 1'b1;
              else token_count_next = token_count + 1'b1;
            end else begin
              do_flush = 1'b1;
              run_idle = 1'b1;
            end
          end
          MODE_STRING: begin
            if (char_code == stc_pkg::CH_QUOTE) begin
              do_flush = 1'b1;
            end else if (token_count == POS_MAX) begin
              position_saturated_next = 1'b1;
            end else begin
              token_count_next = token_count + 1'b1;
            end
          end
          MODE_OPER: begin
            do_flush = 1'b1;
            if (char_code == stc_pkg::CH_EQUAL) begin
              if (held_operator == stc_pkg::CH_PLUS || held_operator == stc_pkg::CH_MINUS ||
                  held_operator == stc_pkg::CH_STAR || held_operator == stc_pkg::CH_SLASH) begin
                flush_tok.kind = stc_pkg::KIND_ASSIGN;
              end else begin
                flush_tok.kind   = stc_pkg::KIND_COMP;
                flush_tok.length = 16'd2;
                flush_tok.second = stc_pkg::CH_EQUAL;
              end
            end else if ((held_operator == stc_pkg::CH_LESS ||
                          held_operator == stc_pkg::CH_GREATER) &&
                         char_code == held_operator) begin
              // shift operator
              flush_tok.kind   = stc_pkg::KIND_OP;
              flush_tok.length = 16'd2;
              flush_tok.second = held_operator;
            end else begin
              run_idle = 1'b1;
            end
          end
          default: run_idle = 1'b1;
        endcase

        if (do_flush) begin
          scan_mode_next     = MODE_IDLE;
          held_operator_next = '0;
          token_begin_next   = '0;
          token_count_next   = '0;
        end else if (run_idle) begin
          scan_mode_next = MODE_IDLE;
        end

        if (run_idle && !stc_pkg::is_space(char_code)) begin
          if (stc_pkg::is_alpha(char_code) || char_code == stc_pkg::CH_UNDERSCORE) begin
            scan_mode_next   = MODE_IDENT;
            token_begin_next = char_position;
            token_count_next = OFFSET_BITS'(1);
          end else if (stc_pkg::is_digit(char_code)) begin
            scan_mode_next   = MODE_INT;
            token_begin_next = char_position;
            token_count_next = OFFSET_BITS'(1);
          end else if (char_code == stc_pkg::CH_QUOTE) begin
            // text starts after the opening quote
            scan_mode_next   = MODE_STRING;
            token_begin_next = (char_position == POS_MAX) ? POS_MAX : char_position + 1'b1;
            token_count_next = '0;
          end else if (stc_pkg::is_oper(char_code)) begin
            scan_mode_next     = MODE_OPER;
            held_operator_next = char_code;
            token_begin_next   = char_position;
            token_count_next   = OFFSET_BITS'(1);
          end else if (pk.hit) begin
            idle_ok        = 1'b1;
            idle_tok.kind  = pk.kind;
            idle_tok.start = clamp16(char_position);
          end else begin
            idle_ok         = 1'b1;
            idle_tok.kind   = stc_pkg::KIND_UNKNOWN;
            idle_tok.start  = clamp16(char_position);
            idle_tok.length = 16'd1;
            idle_tok.first  = char_code;
          end
        end
      end
    end

    flush_tok.overflow = ovf;
    idle_tok.overflow  = ovf;
    n_tok = {1'b0, do_flush} + {1'b0, idle_ok};
    slot0 = do_flush ? flush_tok : idle_tok;
    slot0.last = (n_tok == 2'd1);
    slot1 = idle_tok;
    slot1.last = 1'b1;
    fill_next = fill + {1'b0, n_tok} - {2'b00, out_accept};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode          <= MODE_IDLE;
      held_operator      <= '0;
      token_begin        <= '0;
      token_count        <= '0;
      char_position      <= '0;
      position_saturated <= 1'b0;
      wr_ptr             <= '0;
      rd_ptr             <= '0;
      fill               <= '0;
    end else begin
      scan_mode          <= scan_mode_next;
      held_operator      <= held_operator_next;
      token_begin        <= token_begin_next;
      token_count        <= token_count_next;
      char_position      <= char_position_next;
      position_saturated <= position_saturated_next;
      wr_ptr             <= wr_ptr + n_tok;
      if (out_accept) rd_ptr <= rd_ptr + 2'd1;
      fill               <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_tok != 2'd0) tok_fifo[wr_ptr] <= slot0;
    if (n_tok == 2'd2) tok_fifo[wr_ptr + 2'd1] <= slot1;
  end

  assign token_kind      = tok_fifo[rd_ptr].kind;
  assign token_start     = tok_fifo[rd_ptr].start;
  assign token_length    = tok_fifo[rd_ptr].length;
  assign text_first      = tok_fifo[rd_ptr].first;
  assign text_second     = tok_fifo[rd_ptr].second;
  assign offset_overflow = tok_fifo[rd_ptr].overflow;
  assign last_of_run     = tok_fifo[rd_ptr].last;

endmodule

// File: tb/sv/tb_source_char_tokenizer.sv
module tb_source_char_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_BITS = 16;
  localparam longint unsigned POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam int RANDOM_CHARS = 1650;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 10;

  localparam string IDENT_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IDENT_TAIL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string DIGITS = "0123456789";
  localparam string OPER_CHARS = "+-*/=!<>";
  localparam string PUNCT_CHARS = "(){}[],.:;";

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IDENT,
    ST_NUMBER,
    ST_QUOTED,
    ST_OPER
  } scan_t;

  typedef struct {
    logic [7:0]  c;
    logic        eos;
    bit          typed;
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  first;
    logic [7:0]  second;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'd0;
  logic        end_of_source = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [7:0]  text_first;
  logic [7:0]  text_second;
  logic        offset_overflow;
  logic        last_of_run;

  source_char_tokenizer #(.OFFSET_BITS(OFFSET_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .end_of_source(end_of_source),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .token_start(token_start),
    .token_length(token_length),
    .text_first(text_first),
    .text_second(text_second),
    .offset_overflow(offset_overflow),
    .last_of_run(last_of_run)
  );

  always #5 clk = ~clk;

  // scanner state mirrored from the block
  scan_t           scan_mode;
  logic [7:0]      held_char;
  longint unsigned tok_begin;
  longint unsigned tok_count;
  longint unsigned char_pos;
  bit              pos_sat;

  stc_pkg::token_t step_tokens[2];
  int              step_count;
  stc_pkg::token_t pending_tokens[$];

  bit              typed_on = 1'b0;
  stc_pkg::token_t typed_tok = '0;
  bit              calm = 1'b0;
  int              error_count = 0;
  int              chars_sent = 0;
  int              quiet_cycles = 0;

  function automatic void emit_token(logic [4:0] kind, longint unsigned start,
                                     longint unsigned len, logic [7:0] a, logic [7:0] b);
    stc_pkg::token_t t;
    t.kind     = kind;
    t.start    = (start > 64'hFFFF) ? 16'hFFFF : start[15:0];
    t.length   = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
    t.first    = a;
    t.second   = b;
    t.overflow = pos_sat;
    t.last     = 1'b0;
    step_tokens[step_count] = t;
    step_count++;
  endfunction

  function automatic void clear_pending();
    scan_mode = ST_IDLE;
    held_char = 8'd0;
    tok_begin = 64'd0;
    tok_count = 64'd0;
  endfunction

  function automatic void reset_scanner();
    clear_pending();
    char_pos = 64'd0;
    pos_sat  = 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == stc_pkg::CH_SPACE || (c >= stc_pkg::CH_TAB && c <= stc_pkg::CH_CR);
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_op_char(logic [7:0] c);
    return c == stc_pkg::CH_PLUS || c == stc_pkg::CH_MINUS || c == stc_pkg::CH_STAR ||
           c == stc_pkg::CH_SLASH || c == stc_pkg::CH_EQUAL || c == stc_pkg::CH_BANG ||
           c == stc_pkg::CH_LESS || c == stc_pkg::CH_GREATER;
  endfunction

  function automatic logic [4:0] single_op_kind(logic [7:0] h);
    if (h == stc_pkg::CH_EQUAL) return stc_pkg::KIND_ASSIGN;
    if (h == stc_pkg::CH_LESS || h == stc_pkg::CH_GREATER) return stc_pkg::KIND_COMP;
    return stc_pkg::KIND_OP;
  endfunction

  function automatic void flush_token();
    case (scan_mode)
      ST_IDENT:  emit_token(stc_pkg::KIND_ID, tok_begin, tok_count, 8'd0, 8'd0);
      ST_NUMBER: emit_token(stc_pkg::KIND_INT, tok_begin, tok_count, 8'd0, 8'd0);
      ST_QUOTED: emit_token(stc_pkg::KIND_STRING, tok_begin, tok_count, 8'd0, 8'd0);
      ST_OPER:   emit_token(single_op_kind(held_char), tok_begin, 64'd1, held_char, 8'd0);
      default: ;
    endcase
    clear_pending();
  endfunction

  function automatic void count_up();
    if (tok_count < POS_MAX) tok_count++;
    else pos_sat = 1'b1;
  endfunction

  function automatic void start_token(logic [7:0] c, longint unsigned p);
    logic [4:0] kind;
    kind = stc_pkg::KIND_UNKNOWN;
    if (is_blank(c)) return;
    if (is_letter(c) || c == stc_pkg::CH_UNDERSCORE) begin
      scan_mode = ST_IDENT;
      tok_begin = p;
      tok_count = 64'd1;
    end else if (is_num(c)) begin
      scan_mode = ST_NUMBER;
      tok_begin = p;
      tok_count = 64'd1;
    end else if (c == stc_pkg::CH_QUOTE) begin
      // string text starts after the quote
      scan_mode = ST_QUOTED;
      tok_begin = (p < POS_MAX) ? p + 64'd1 : POS_MAX;
      tok_count = 64'd0;
    end else if (is_op_char(c)) begin
      scan_mode = ST_OPER;
      held_char = c;
      tok_begin = p;
      tok_count = 64'd1;
    end else begin
      case (c)
        stc_pkg::CH_LPAREN:    kind = stc_pkg::KIND_LPAREN;
        stc_pkg::CH_RPAREN:    kind = stc_pkg::KIND_RPAREN;
        stc_pkg::CH_LBRACE:    kind = stc_pkg::KIND_LBRACE;
        stc_pkg::CH_RBRACE:    kind = stc_pkg::KIND_RBRACE;
        stc_pkg::CH_LBRACKET:  kind = stc_pkg::KIND_LBRACKET;
        stc_pkg::CH_RBRACKET:  kind = stc_pkg::KIND_RBRACKET;
        stc_pkg::CH_COMMA:     kind = stc_pkg::KIND_COMMA;
        stc_pkg::CH_DOT:       kind = stc_pkg::KIND_DOT;
        stc_pkg::CH_COLON:     kind = stc_pkg::KIND_COLON;
        stc_pkg::CH_SEMICOLON: kind = stc_pkg::KIND_SEMICOLON;
        default:               kind = stc_pkg::KIND_UNKNOWN;
      endcase
      if (kind == stc_pkg::KIND_UNKNOWN) emit_token(stc_pkg::KIND_UNKNOWN, p, 64'd1, c, 8'd0);
      else emit_token(kind, p, 64'd0, 8'd0, 8'd0);
    end
  endfunction

  function automatic void tokenize_char(logic [7:0] c, logic eos);
    longint unsigned p;
    logic [7:0] h;
    step_count = 0;
    if (eos) begin
      flush_token();
      reset_scanner();
    end else begin
      p = char_pos;
      if (char_pos < POS_MAX) char_pos++;
      else pos_sat = 1'b1;
      case (scan_mode)
        ST_IDENT: begin
          if (is_letter(c) || is_num(c) || c == stc_pkg::CH_UNDERSCORE) count_up();
          else begin
            flush_token();
            start_token(c, p);
          end
        end
        ST_NUMBER: begin
          if (is_num(c)) count_up();
          else begin
            flush_token();
            start_token(c, p);
          end
        end
        ST_QUOTED: begin
          if (c == stc_pkg::CH_QUOTE) flush_token();
          else count_up();
        end
        ST_OPER: begin
          h = held_char;
          if (c == stc_pkg::CH_EQUAL) begin
            // compound assign keeps only the operator character
            if (h == stc_pkg::CH_PLUS || h == stc_pkg::CH_MINUS ||
                h == stc_pkg::CH_STAR || h == stc_pkg::CH_SLASH)
              emit_token(stc_pkg::KIND_ASSIGN, tok_begin, 64'd1, h, 8'd0);
            else
              emit_token(stc_pkg::KIND_COMP, tok_begin, 64'd2, h, stc_pkg::CH_EQUAL);
            clear_pending();
          end else if ((h == stc_pkg::CH_LESS || h == stc_pkg::CH_GREATER) && c == h) begin
            emit_token(stc_pkg::KIND_OP, tok_begin, 64'd2, h, h);
            clear_pending();
          end else begin
            flush_token();
            start_token(c, p);
          end
        end
        default: start_token(c, p);
      endcase
    end
    if (step_count > 0) step_tokens[step_count - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  initial reset_scanner();

  // scoreboard: predict on every input transaction, compare every output transaction
  always @(posedge clk) begin
    stc_pkg::token_t got;
    stc_pkg::token_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        tokenize_char(char_code, end_of_source);
        if (typed_on) pending_tokens.push_back(typed_tok);
        else for (int i = 0; i < step_count; i++) pending_tokens.push_back(step_tokens[i]);
      end
      if (out_valid && !out_stall) begin
        got = {token_kind, token_start, token_length, text_first, text_second,
               offset_overflow, last_of_run};
        if (pending_tokens.size() == 0) begin
          $display("%0t: unexpected token: expected none, got kind %0d start %0d length %0d",
                   $time, token_kind, token_start, token_length);
          error_count++;
        end else begin
          want = pending_tokens.pop_front();
          check_field("token_kind", 32'(want.kind), 32'(got.kind));
          check_field("token_start", 32'(want.start), 32'(got.start));
          check_field("token_length", 32'(want.length), 32'(got.length));
          check_field("text_first", 32'(want.first), 32'(got.first));
          check_field("text_second", 32'(want.second), 32'(got.second));
          check_field("offset_overflow", 32'(want.overflow), 32'(got.overflow));
          check_field("last_of_run", 32'(want.last), 32'(got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
        $display("** source_char_tokenizer: FAILED **");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= !calm && ($urandom_range(99) < 17);

  // entered and left at a falling edge; valid stays high after acceptance
  task automatic push_char(input logic [7:0] c, input logic eos,
                           input bit typed = 1'b0, input stc_pkg::token_t tt = '0);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    char_code     = c;
    end_of_source = eos;
    typed_on      = typed;
    typed_tok     = tt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send(input logic [7:0] c);
    push_char(c, 1'b0);
  endtask

  task automatic wait_for_tokens();
    in_valid = 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic send_lexeme();
    int pick;
    int n;
    logic [7:0] c;
    pick = $urandom_range(99);
    n = $urandom_range(12, 1);
    if (pick < 20) begin
      send(pick_char(IDENT_HEAD));
      repeat (n - 1) send(pick_char(IDENT_TAIL));
    end else if (pick < 32) begin
      repeat (n) send(pick_char(DIGITS));
    end else if (pick < 42) begin
      send(stc_pkg::CH_QUOTE);
      repeat (n) begin
        c = 8'($urandom_range(255));
        if (c == stc_pkg::CH_QUOTE) c = stc_pkg::CH_SPACE;
        send(c);
      end
      // leave a few strings open
      if ($urandom_range(9) != 0) send(stc_pkg::CH_QUOTE);
    end else if (pick < 60) begin
      send(pick_char(OPER_CHARS));
      if ($urandom_range(1)) send(pick_char(OPER_CHARS));
    end else if (pick < 70) begin
      send(pick_char(PUNCT_CHARS));
    end else if (pick < 80) begin
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(1)) send(stc_pkg::CH_SPACE);
        else send(8'($urandom_range(stc_pkg::CH_CR, stc_pkg::CH_TAB)));
      end
    end else if (pick < 88) begin
      send(8'($urandom_range(255)));
    end else if (pick < 91) begin
      push_char(8'($urandom_range(255)), 1'b1);
    end else begin
      send(stc_pkg::CH_SPACE);
    end
  endtask

  script_row_t script[26];

  initial begin
    stc_pkg::token_t tt;
    script = '{
      '{stc_pkg::CH_LPAREN, 1'b0, 1'b1, stc_pkg::KIND_LPAREN, 16'd0, 16'd0, 8'd0, 8'd0},
      '{8'hFF, 1'b0, 1'b1, stc_pkg::KIND_UNKNOWN, 16'd1, 16'd1, 8'hFF, 8'd0},
      '{"A", 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_UNDERSCORE, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{"z", 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{"9", 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_PLUS, 1'b0, 1'b1, stc_pkg::KIND_ID, 16'd2, 16'd4, 8'd0, 8'd0},
      '{stc_pkg::CH_EQUAL, 1'b0, 1'b1, stc_pkg::KIND_ASSIGN, 16'd6, 16'd1,
        stc_pkg::CH_PLUS, 8'd0},
      '{stc_pkg::CH_LESS, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_LESS, 1'b0, 1'b1, stc_pkg::KIND_OP, 16'd8, 16'd2,
        stc_pkg::CH_LESS, stc_pkg::CH_LESS},
      '{stc_pkg::CH_BANG, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_EQUAL, 1'b0, 1'b1, stc_pkg::KIND_COMP, 16'd10, 16'd2,
        stc_pkg::CH_BANG, stc_pkg::CH_EQUAL},
      '{stc_pkg::CH_GREATER, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_SEMICOLON, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{"0", 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_MINUS, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_TAB, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{8'h80, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{stc_pkg::CH_QUOTE, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{"q", 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{8'h00, 1'b1, 1'b1, stc_pkg::KIND_STRING, 16'd22, 16'd1, 8'd0, 8'd0},
      '{stc_pkg::CH_SPACE, 1'b0, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0},
      '{8'hFF, 1'b1, 1'b0, stc_pkg::KIND_ID, 16'd0, 16'd0, 8'd0, 8'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i]) begin
      tt = {script[i].kind, script[i].start, script[i].length, script[i].first,
            script[i].second, 1'b0, 1'b1};
      push_char(script[i].c, script[i].eos, script[i].typed, tt);
    end
    typed_on = 1'b0;
    wait_for_tokens();

    chars_sent = 0;
    while (chars_sent < RANDOM_CHARS) begin
      calm = chars_sent >= 700 && chars_sent < 1000;
      send_lexeme();
    end
    calm = 1'b0;
    wait_for_tokens();

    // empty string, then open string and held operator flushed at end of source
    push_char(stc_pkg::CH_SPACE, 1'b1);
    send(stc_pkg::CH_QUOTE);
    send(stc_pkg::CH_QUOTE);
    send("x");
    send("y");
    send(stc_pkg::CH_SPACE);
    send(stc_pkg::CH_QUOTE);
    send("k");
    push_char(8'h00, 1'b1);
    send("a");
    send(stc_pkg::CH_GREATER);
    push_char(8'h00, 1'b1);

    wait_for_tokens();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("** source_char_tokenizer: PASSED **");
    end else begin
      $display("** source_char_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule
